/* hdl/tbo_pkg.sv */
// ----------------------------------------------------------------------------
// tbo_pkg
// Shared types, constants and width helpers for the barycentric weight core.
// ----------------------------------------------------------------------------
`default_nettype none

package tbo_pkg;

  // Default coordinate format: signed, COORD_BITS wide, FRAC_BITS fraction bits
  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Fixed widths of the beat fields
  localparam int FIELD_BITS  = 32;
  localparam int WEIGHT_BITS = 32;

  // Limb width of the partial-product multipliers
  localparam int LIMB_BITS = 32;

  // Divider latency: setup, range check, one stage per quotient bit, output
  localparam int DIV_LAT = WEIGHT_BITS + 3;

  // Input beat: three vertices
  typedef struct packed {
    logic signed [FIELD_BITS-1:0] v0_x;
    logic signed [FIELD_BITS-1:0] v0_y;
    logic signed [FIELD_BITS-1:0] v0_z;
    logic signed [FIELD_BITS-1:0] v1_x;
    logic signed [FIELD_BITS-1:0] v1_y;
    logic signed [FIELD_BITS-1:0] v1_z;
    logic signed [FIELD_BITS-1:0] v2_x;
    logic signed [FIELD_BITS-1:0] v2_y;
    logic signed [FIELD_BITS-1:0] v2_z;
  } vtx_beat_t;

  // Output beat: three weights and the degenerate flag
  typedef struct packed {
    logic signed [WEIGHT_BITS-1:0] weight_0;
    logic signed [WEIGHT_BITS-1:0] weight_1;
    logic signed [WEIGHT_BITS-1:0] weight_2;
    logic                          degenerate;
  } wgt_beat_t;

  // Number of limbs needed for an operand of w bits
  function automatic int limbs(input int w);
    return (w + LIMB_BITS - 1) / LIMB_BITS;
  endfunction

  // Multiplier latency for a given number of accumulate stages
  function automatic int mul_lat(input int nps);
    return nps + 3;
  endfunction

endpackage

`default_nettype wire

/* hdl/triangle_barycentric_of_origin_core.sv */
// ----------------------------------------------------------------------------
// triangle_barycentric_of_origin_core
// Barycentric weights of the origin's projection onto a triangle's plane:
// weight_i = n.(s_j x s_k) / n.n with n = (s1-s0) x (s2-s0), exact products.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake               Payload
//  vtx      in   vtx_valid / vtx_ready   tbo_pkg::vtx_beat_t (three vertices)
//  wgt      out  wgt_valid / wgt_ready   tbo_pkg::wgt_beat_t (weights, flag)
//
//  One beat per cycle in and out while wgt does not stall; the pipeline
//  runs through the two limb-multiplier levels and the one-bit-per-stage
//  divider. Reset clears the valid pipeline only.
//  A stall on wgt freezes the whole pipeline; vtx_ready drops with it.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_barycentric_of_origin_core #(
  parameter int COORD_BITS = tbo_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = tbo_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                vtx_valid,
  output logic                vtx_ready,
  input  tbo_pkg::vtx_beat_t  vtx,
  output logic                wgt_valid,
  input  logic                wgt_ready,
  output tbo_pkg::wgt_beat_t  wgt
);

  localparam int CW   = COORD_BITS;
  localparam int EW   = CW + 1;
  localparam int NW   = 2 * EW + 1;
  localparam int CCW  = 2 * CW + 1;
  localparam int DW   = 2 * NW + 2;
  localparam int UW   = NW + CCW + 2;
  localparam int NP1  = tbo_pkg::limbs(EW) * tbo_pkg::limbs(EW);
  localparam int NP2  = tbo_pkg::limbs(NW) * tbo_pkg::limbs(NW);
  localparam int DL   = tbo_pkg::DIV_LAT;
  localparam int LAT  = 1 + tbo_pkg::mul_lat(NP1) + 1 + tbo_pkg::mul_lat(NP2) + 2 + DL + 1;
  localparam int WB   = tbo_pkg::WEIGHT_BITS;

  logic             en;
  logic [LAT-1:0]   vp;
  logic [DL-1:0]    dz;

  logic [CW-1:0]    s   [3][3];
  logic [CW-1:0]    sr  [3][3];
  logic [EW-1:0]    e1  [3];
  logic [EW-1:0]    e2  [3];
  logic [2*EW-1:0]  npa [3];
  logic [2*EW-1:0]  npb [3];
  logic [2*CW-1:0]  cpa [3][3];
  logic [2*CW-1:0]  cpb [3][3];
  logic [NW-1:0]    nv  [3];
  logic [CCW-1:0]   cv  [3][3];
  logic [2*NW-1:0]  dp  [3];
  logic [NW+CCW-1:0] up [3][3];
  logic [DW-1:0]    dsa;
  logic [2*NW-1:0]  dp2r;
  logic [UW-1:0]    usa  [3];
  logic [NW+CCW-1:0] up2r [3];
  logic [DW-1:0]    den;
  logic [UW-1:0]    num  [3];
  logic [WB-1:0]    q    [3];

  // Global advance: the pipeline moves unless the output beat is held
  assign en        = !vp[LAT-1] || wgt_ready;
  assign vtx_ready = en;
  assign wgt_valid = vp[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= '0;
    end else if (en) begin
      vp <= {vp[LAT-2:0], vtx_valid};
    end
  end

  // Coordinates read at COORD_BITS with sign extension
  always_comb begin
    s[0][0] = CW'(vtx.v0_x);
    s[0][1] = CW'(vtx.v0_y);
    s[0][2] = CW'(vtx.v0_z);
    s[1][0] = CW'(vtx.v1_x);
    s[1][1] = CW'(vtx.v1_y);
    s[1][2] = CW'(vtx.v1_z);
    s[2][0] = CW'(vtx.v2_x);
    s[2][1] = CW'(vtx.v2_y);
    s[2][2] = CW'(vtx.v2_z);
  end

  // Edge vectors
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        e1[k] <= EW'($signed(s[1][k])) - EW'($signed(s[0][k]));
        e2[k] <= EW'($signed(s[2][k])) - EW'($signed(s[0][k]));
        for (int i = 0; i < 3; i++) begin
          sr[i][k] <= s[i][k];
        end
      end
    end
  end

  // First product level: normal and vertex cross products
  for (genvar m = 0; m < 3; m++) begin : g_l1
    localparam int A = (m + 1) % 3;
    localparam int B = (m + 2) % 3;
    tbo_mul #(.AW(EW), .BW(EW), .NPS(NP1)) u_npa (
      .clk(clk), .en(en), .a(e1[A]), .b(e2[B]), .p(npa[m])
    );
    tbo_mul #(.AW(EW), .BW(EW), .NPS(NP1)) u_npb (
      .clk(clk), .en(en), .a(e1[B]), .b(e2[A]), .p(npb[m])
    );
    for (genvar i = 0; i < 3; i++) begin : g_c
      localparam int J = (i + 1) % 3;
      localparam int K = (i + 2) % 3;
      tbo_mul #(.AW(CW), .BW(CW), .NPS(NP1)) u_cpa (
        .clk(clk), .en(en), .a(sr[J][A]), .b(sr[K][B]), .p(cpa[i][m])
      );
      tbo_mul #(.AW(CW), .BW(CW), .NPS(NP1)) u_cpb (
        .clk(clk), .en(en), .a(sr[J][B]), .b(sr[K][A]), .p(cpb[i][m])
      );
    end
  end

  // Cross product differences
  always_ff @(posedge clk) begin
    if (en) begin
      for (int m = 0; m < 3; m++) begin
        nv[m] <= NW'($signed(npa[m])) - NW'($signed(npb[m]));
        for (int i = 0; i < 3; i++) begin
          cv[i][m] <= CCW'($signed(cpa[i][m])) - CCW'($signed(cpb[i][m]));
        end
      end
    end
  end

  // Second product level: n.n and n.c terms
  for (genvar m = 0; m < 3; m++) begin : g_l2
    tbo_mul #(.AW(NW), .BW(NW), .NPS(NP2)) u_dp (
      .clk(clk), .en(en), .a(nv[m]), .b(nv[m]), .p(dp[m])
    );
    for (genvar i = 0; i < 3; i++) begin : g_u
      tbo_mul #(.AW(NW), .BW(CCW), .NPS(NP2)) u_up (
        .clk(clk), .en(en), .a(nv[m]), .b(cv[i][m]), .p(up[i][m])
      );
    end
  end

  // Dot product sums over two stages
  always_ff @(posedge clk) begin
    if (en) begin
      dsa  <= DW'($signed(dp[0])) + DW'($signed(dp[1]));
      dp2r <= dp[2];
      for (int i = 0; i < 3; i++) begin
        usa[i]  <= UW'($signed(up[i][0])) + UW'($signed(up[i][1]));
        up2r[i] <= up[i][2];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den <= dsa + DW'($signed(dp2r));
      for (int i = 0; i < 3; i++) begin
        num[i] <= usa[i] + UW'($signed(up2r[i]));
      end
    end
  end

  // Degenerate flag travels alongside the dividers
  always_ff @(posedge clk) begin
    if (en) begin
      dz <= {dz[DL-2:0], (den == '0)};
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    tbo_div #(.NW(UW), .DW(DW), .FRAC(FRAC_BITS)) u_div (
      .clk(clk), .en(en), .num(num[i]), .den(den), .q(q[i])
    );
  end

  // Output register
  always_ff @(posedge clk) begin
    if (en) begin
      wgt.weight_0   <= dz[DL-1] ? '0 : q[0];
      wgt.weight_1   <= dz[DL-1] ? '0 : q[1];
      wgt.weight_2   <= dz[DL-1] ? '0 : q[2];
      wgt.degenerate <= dz[DL-1];
    end
  end

endmodule

`default_nettype wire

/* hdl/tbo_mul.sv */
// ----------------------------------------------------------------------------
// tbo_mul
// Pipelined signed multiplier built from 32x32 limb products, summed one
// partial product per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tbo_mul #(
  parameter int AW  = 33,
  parameter int BW  = 33,
  parameter int NPS = 4
) (
  input  logic              clk,
  input  logic              en,
  input  logic [AW-1:0]     a,
  input  logic [BW-1:0]     b,
  output logic [AW+BW-1:0]  p
);

  localparam int LB = tbo_pkg::LIMB_BITS;
  localparam int NA = tbo_pkg::limbs(AW);
  localparam int NB = tbo_pkg::limbs(BW);
  localparam int NP = NA * NB;
  localparam int XW = LB * (NA + NB);
  localparam int PW = AW + BW;

  logic [AW-1:0]                amag;
  logic [BW-1:0]                bmag;
  logic [LB*NA-1:0]             aext;
  logic [LB*NB-1:0]             bext;
  logic [NP-1:0][2*LB-1:0]      pps [NP];
  logic [XW-1:0]                acc [1:NPS];
  logic                         sg  [NPS+2];

  // Magnitudes and product sign
  always_ff @(posedge clk) begin
    if (en) begin
      amag  <= a[AW-1] ? (~a + AW'(1)) : a;
      bmag  <= b[BW-1] ? (~b + BW'(1)) : b;
      sg[0] <= a[AW-1] ^ b[BW-1];
    end
  end

  assign aext = (LB*NA)'(amag);
  assign bext = (LB*NB)'(bmag);

  // Limb products, all in parallel
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pps[0][i*NB+j] <= (2*LB)'(aext[i*LB +: LB]) * (2*LB)'(bext[j*LB +: LB]);
        end
      end
      sg[1] <= sg[0];
    end
  end

  // One partial product added per stage
  for (genvar k = 0; k < NPS; k++) begin : g_acc
    logic [XW-1:0] term;
    logic [XW-1:0] base;
    if (k < NP) begin : g_add
      assign term = XW'(pps[k][k]) << (LB * ((k / NB) + (k % NB)));
    end else begin : g_pass
      assign term = '0;
    end
    // First stage starts from zero
    if (k == 0) begin : g_first
      assign base = '0;
    end else begin : g_next
      assign base = acc[k];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        acc[k+1] <= base + term;
        sg[k+2]  <= sg[k+1];
      end
    end
    if (k + 1 < NP) begin : g_pp
      always_ff @(posedge clk) begin
        if (en) begin
          pps[k+1] <= pps[k];
        end
      end
    end
  end

  // Restore the sign
  always_ff @(posedge clk) begin
    if (en) begin
      p <= sg[NPS+1] ? PW'(~acc[NPS] + XW'(1)) : PW'(acc[NPS]);
    end
  end

endmodule

`default_nettype wire

/* hdl/tbo_div.sv */
// ----------------------------------------------------------------------------
// tbo_div
// Pipelined restoring divider: round(num * 2^FRAC / den), ties away from
// zero, saturated to a signed weight. One quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tbo_div #(
  parameter int NW   = 136,
  parameter int DW   = 136,
  parameter int FRAC = 16
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic [NW-1:0]                      num,
  input  logic [DW-1:0]                      den,
  output logic [tbo_pkg::WEIGHT_BITS-1:0]    q
);

  localparam int WB  = tbo_pkg::WEIGHT_BITS;
  localparam int RA  = NW + FRAC + 2;
  localparam int RB  = DW + WB + 2;
  localparam int RW  = (RA > RB) ? RA : RB;
  localparam int D2W = DW + 1;
  localparam logic [WB-1:0] POS_MAX = {1'b0, {(WB-1){1'b1}}};
  localparam logic [WB-1:0] NEG_MAX = {1'b1, {(WB-1){1'b0}}};

  logic [NW-1:0]  mag;
  logic [RW-1:0]  rem [WB+1];
  logic [D2W-1:0] d2  [WB+1];
  logic           neg [WB+2];
  logic           sat [WB+1];
  logic [WB-1:0]  qa  [1:WB];

  assign mag = num[NW-1] ? (~num + NW'(1)) : num;

  // Scaled magnitude plus half divisor for rounding
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= (RW'(mag) << (FRAC + 1)) + RW'(den);
      d2[0]  <= D2W'(den) << 1;
      neg[0] <= num[NW-1];
    end
  end

  // Range check against the full quotient width
  always_ff @(posedge clk) begin
    if (en) begin
      sat[0] <= rem[0] >= (RW'(d2[0]) << WB);
      rem[1] <= rem[0];
      d2[1]  <= d2[0];
      neg[1] <= neg[0];
    end
  end

  // Quotient bits, MSB first
  for (genvar t = 0; t < WB; t++) begin : g_bit
    logic [RW-1:0] trial;
    logic          take;
    logic [WB-1:0] qprev;
    assign trial = RW'(d2[t+1]) << (WB - 1 - t);
    assign take  = rem[t+1] >= trial;
    // Partial quotient starts empty
    if (t == 0) begin : g_first
      assign qprev = '0;
    end else begin : g_next
      assign qprev = qa[t];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        qa[t+1]  <= {qprev[WB-2:0], take};
        sat[t+1] <= sat[t];
        neg[t+2] <= neg[t+1];
      end
    end
    if (t < WB - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        if (en) begin
          rem[t+2] <= take ? (rem[t+1] - trial) : rem[t+1];
          d2[t+2]  <= d2[t+1];
        end
      end
    end
  end

  // Sign and saturation
  always_ff @(posedge clk) begin
    if (en) begin
      if (sat[WB]) begin
        q <= neg[WB+1] ? NEG_MAX : POS_MAX;
      end else if (!neg[WB+1]) begin
        q <= (qa[WB] > POS_MAX) ? POS_MAX : qa[WB];
      end else begin
        q <= (qa[WB] > NEG_MAX) ? NEG_MAX : (~qa[WB] + WB'(1));
      end
    end
  end

endmodule

`default_nettype wire

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the barycentric weight core. Triangles are streamed in with
// random gaps while the result side stalls at random. Each accepted triangle
// is run through an exact wide-integer predictor, and the expected weights
// are queued. Results are compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int FRAC    = 16;
  localparam int LIMIT   = 600000;
  localparam int DRAIN   = 120;
  localparam int N_RAND  = 1200;

  logic               clk;
  logic               rst;
  logic               vtx_valid;
  logic               vtx_ready;
  tbo_pkg::vtx_beat_t vtx;
  logic               wgt_valid;
  logic               wgt_ready;
  tbo_pkg::wgt_beat_t wgt;

  tbo_pkg::wgt_beat_t pending_wgts[$];
  int                 mismatches;
  int                 cycles;
  bit                 quiet;

  triangle_barycentric_of_origin_core uut (
    .clk(clk), .rst(rst),
    .vtx_valid(vtx_valid), .vtx_ready(vtx_ready), .vtx(vtx),
    .wgt_valid(wgt_valid), .wgt_ready(wgt_ready), .wgt(wgt)
  );

  // Clock and cycle limit
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Rounded, saturated num * 2^FRAC / den, ties away from zero
  function automatic logic [31:0] scaled_weight(logic signed [255:0] num,
                                                logic [255:0] den);
    logic [255:0] mag;
    logic [255:0] q;
    mag = num[255] ? -num : num;
    q = ((mag << (FRAC + 1)) + den) / (den << 1);
    if (!num[255])
      return (q > 256'h7FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
    if (q > 256'h80000000)
      return 32'h80000000;
    return -q[31:0];
  endfunction

  // Exact barycentric weights of the origin's projection
  function automatic tbo_pkg::wgt_beat_t bary_weights(tbo_pkg::vtx_beat_t b);
    logic signed [255:0] s[3][3];
    logic signed [255:0] e1[3], e2[3], nrm[3], c[3];
    logic signed [255:0] num;
    logic [255:0]        den;
    tbo_pkg::wgt_beat_t  r;
    int                  j, k;
    s[0][0] = $signed(b.v0_x); s[0][1] = $signed(b.v0_y); s[0][2] = $signed(b.v0_z);
    s[1][0] = $signed(b.v1_x); s[1][1] = $signed(b.v1_y); s[1][2] = $signed(b.v1_z);
    s[2][0] = $signed(b.v2_x); s[2][1] = $signed(b.v2_y); s[2][2] = $signed(b.v2_z);
    for (k = 0; k < 3; k++) begin
      e1[k] = s[1][k] - s[0][k];
      e2[k] = s[2][k] - s[0][k];
    end
    for (k = 0; k < 3; k++)
      nrm[k] = e1[(k+1)%3] * e2[(k+2)%3] - e1[(k+2)%3] * e2[(k+1)%3];
    den = nrm[0] * nrm[0] + nrm[1] * nrm[1] + nrm[2] * nrm[2];
    r = '0;
    if (den == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    for (j = 0; j < 3; j++) begin
      for (k = 0; k < 3; k++)
        c[k] = s[(j+1)%3][(k+1)%3] * s[(j+2)%3][(k+2)%3]
             - s[(j+1)%3][(k+2)%3] * s[(j+2)%3][(k+1)%3];
      num = nrm[0] * c[0] + nrm[1] * c[1] + nrm[2] * c[2];
      case (j)
        0: r.weight_0 = scaled_weight(num, den);
        1: r.weight_1 = scaled_weight(num, den);
        default: r.weight_2 = scaled_weight(num, den);
      endcase
    end
    return r;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int gap_len();
    if (quiet || $urandom_range(0, 2) == 0)
      return 0;
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  // Send one triangle; returns after the accepting edge
  task automatic send_tri(tbo_pkg::vtx_beat_t b);
    int g;
    g = gap_len();
    if (g > 0) begin
      vtx_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    vtx       <= b;
    vtx_valid <= 1'b1;
    forever begin
      @(negedge clk);
      if (vtx_ready) break;
    end
    @(posedge clk);
    pending_wgts.insert(pending_wgts.size(), bary_weights(b));
  endtask

  // Result side back-pressure
  initial begin
    wgt_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (quiet || $urandom_range(0, 3) != 0) begin
        wgt_ready <= 1'b1;
      end else begin
        wgt_ready <= 1'b0;
        repeat ((($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                              : $urandom_range(1, 3)) - 1)
          @(posedge clk);
      end
    end
  end

  // Result checker: the beat seen mid-cycle is taken at the next edge
  always @(negedge clk) begin
    tbo_pkg::wgt_beat_t exp_w;
    if (!rst && wgt_valid && wgt_ready) begin
      if (pending_wgts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat %h", wgt);
      end else begin
        exp_w = pending_wgts.pop_front();
        if (wgt.weight_0 !== exp_w.weight_0 || wgt.weight_1 !== exp_w.weight_1 ||
            wgt.weight_2 !== exp_w.weight_2 || wgt.degenerate !== exp_w.degenerate) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp w0=%h w1=%h w2=%h deg=%b, got w0=%h w1=%h w2=%h deg=%b",
                     exp_w.weight_0, exp_w.weight_1, exp_w.weight_2, exp_w.degenerate,
                     wgt.weight_0, wgt.weight_1, wgt.weight_2, wgt.degenerate);
        end
      end
    end
  end

  function automatic tbo_pkg::vtx_beat_t mk_tri(int ax, int ay, int az,
                                                int bx, int by, int bz,
                                                int cx, int cy, int cz);
    tbo_pkg::vtx_beat_t t;
    t.v0_x = ax; t.v0_y = ay; t.v0_z = az;
    t.v1_x = bx; t.v1_y = by; t.v1_z = bz;
    t.v2_x = cx; t.v2_y = cy; t.v2_z = cz;
    return t;
  endfunction

  // Field extremes and all-bits patterns
  task automatic test_extremes();
    localparam int MX = 32'h7FFFFFFF;
    localparam int MN = 32'h80000000;
    send_tri(mk_tri(MX, MX, MX, MX, MX, MX, MX, MX, MX));
    send_tri(mk_tri(MN, MN, MN, MN, MN, MN, MN, MN, MN));
    send_tri(mk_tri(MX, MN, 0, MN, MX, 0, 0, 0, MX));
    send_tri(mk_tri(MN, 0, 0, 0, MN, 0, 0, 0, MN));
    send_tri(mk_tri(MX, 0, 0, 0, MX, 0, 0, 0, MX));
    send_tri(mk_tri(MX, MN, MX, MN, MX, MN, -1, -1, -1));
    send_tri(mk_tri(-1, 0, -1, 0, -1, 0, 1, 1, -1));
  endtask

  // Well-formed triangles with known weights, including the origin on a vertex
  task automatic test_plain();
    send_tri(mk_tri(65536, 0, 0, 0, 65536, 0, 0, 0, 65536));
    send_tri(mk_tri(-65536, -65536, 0, 131072, -65536, 0, -65536, 131072, 0));
    send_tri(mk_tri(0, 0, 0, 65536, 0, 0, 0, 65536, 0));
    send_tri(mk_tri(65536, 0, 65536, 0, 65536, 65536, 0, 0, 65536));
    send_tri(mk_tri(3, 0, 0, 0, 3, 0, 0, 0, 3));
    send_tri(mk_tri(1, 0, 0, 0, 2, 0, 0, 0, 1));
  endtask

  // Collinear and coincident vertices, and weights beyond range
  task automatic test_degenerate_and_saturation();
    send_tri(mk_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_tri(mk_tri(100, 200, 300, 100, 200, 300, 5, 6, 7));
    send_tri(mk_tri(0, 0, 0, 65536, 65536, 65536, 131072, 131072, 131072));
    send_tri(mk_tri(-7, 3, 1, 1, -1, 3, 9, -5, 5));
    send_tri(mk_tri(32'h40000000, 0, 0, 32'h40000001, 0, 0, 32'h40000000, 1, 0));
    send_tri(mk_tri(0, 32'h40000000, 0, 1, 32'h40000000, 0, 0, 32'h40000001, 0));
    send_tri(mk_tri(32'h7FFF0000, 5, 0, 32'h7FFF0001, 5, 0, 32'h7FFF0000, 6, 0));
    send_tri(mk_tri(32'h80010000, 5, 9, 32'h80010000, 6, 9, 32'h80010000, 5, 10));
  endtask

  function automatic int rnd_small();
    return $signed($urandom_range(0, 32'h001FFFFF)) - 32'sh00100000;
  endfunction

  // Random mix: full range, small coordinates, collinear, near degenerate
  task automatic test_random();
    tbo_pkg::vtx_beat_t b;
    int                 kind, dx, dy, dz, m, i;
    for (i = 0; i < N_RAND; i++) begin
      quiet = (i >= 400 && i < 550);
      kind  = $urandom_range(0, 9);
      b = mk_tri(rnd_small(), rnd_small(), rnd_small(), rnd_small(), rnd_small(),
                 rnd_small(), rnd_small(), rnd_small(), rnd_small());
      if (kind < 4) begin
        b = mk_tri($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom);
      end else if (kind == 7) begin
        dx = $urandom_range(0, 2000) - 1000;
        dy = $urandom_range(0, 2000) - 1000;
        dz = $urandom_range(0, 2000) - 1000;
        m  = $urandom_range(0, 200) - 100;
        b.v1_x = b.v0_x + dx;     b.v1_y = b.v0_y + dy;     b.v1_z = b.v0_z + dz;
        b.v2_x = b.v0_x + m * dx; b.v2_y = b.v0_y + m * dy; b.v2_z = b.v0_z + m * dz;
      end else if (kind == 8) begin
        b.v2_x = b.v1_x; b.v2_y = b.v1_y; b.v2_z = b.v1_z;
      end else if (kind == 9) begin
        b.v0_x = $urandom;
        b.v1_x = b.v0_x + $signed($urandom_range(0, 6)) - 3;
        b.v2_x = b.v0_x + $signed($urandom_range(0, 6)) - 3;
        b.v1_y = b.v0_y + $signed($urandom_range(0, 6)) - 3;
        b.v2_z = b.v0_z + $signed($urandom_range(0, 6)) - 3;
      end
      send_tri(b);
    end
    quiet = 1'b0;
  endtask

  // Sequence
  initial begin
    rst        = 1'b1;
    vtx_valid  = 1'b0;
    vtx        = '0;
    mismatches = 0;
    cycles     = 0;
    quiet      = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_plain();
    test_degenerate_and_saturation();
    test_random();
    vtx_valid <= 1'b0;
    while (pending_wgts.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0 && pending_wgts.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

/* triangle_barycentric_of_origin_core.f */
hdl/tbo_pkg.sv
hdl/tbo_mul.sv
hdl/tbo_div.sv
hdl/triangle_barycentric_of_origin_core.sv
test/tb_top.sv
